// ----- design/lbp_pkg.sv -----
// Package for the LRU buffer pool tag controller.
// Status codes, cell commands and controller states. No dependencies.
package lbp_pkg;
   localparam int FRAMES_DEF = 16;
   localparam int FRAME_W    = 4;
   localparam int CSR_W      = 5;
   localparam logic [CSR_W-1:0] FRAMES_IN_USE_RST = 5'd16;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_UNPIN = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_HIT    = 3'd0,
      ST_FILL   = 3'd1,
      ST_BYPASS = 3'd2,
      ST_BUSY   = 3'd3,
      ST_DONE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_MRU,
      CMD_FILL,
      CMD_UNPIN,
      CMD_FREE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [15:0] tbl;
      logic [31:0] page;
      logic        dirty;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_DECIDE,
      S_SCAN
   } state_type;
endpackage

// ----- design/lbp_cell.sv -----
// One frame of the buffer pool: tag, valid/dirty/pinned bits and recency rank.
// Depends on lbp_pkg. Passes the first-match token to the next cell.
module lbp_cell #(
   parameter int FRAMES = lbp_pkg::FRAMES_DEF,
   parameter int RW     = 4,
   parameter int INDEX  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  lbp_pkg::cell_cmd_type cmd,
   input  logic                sel,
   input  logic [RW-1:0]       rank_ref,
   input  logic                in_use,
   input  logic [15:0]         req_table,
   input  logic [31:0]         req_page,
   input  logic                first_in,
   output logic                first_out,
   output logic                hit,
   output logic                valid,
   output logic                dirty,
   output logic                pinned,
   output logic [RW-1:0]       rank,
   output logic [15:0]         tag_table,
   output logic [31:0]         tag_page
);
   import lbp_pkg::*;

   logic          valid_ff, valid_in, dirty_ff, dirty_in, pinned_ff, pinned_in;
   logic [RW-1:0] rank_ff, rank_in;
   logic [15:0]   table_ff, table_in;
   logic [31:0]   page_ff, page_in;
   logic          match;

   assign match     = valid_ff & in_use & (table_ff == req_table) & (page_ff == req_page);
   assign first_out = first_in | match;
   assign hit       = match & ~first_in;

   always_comb begin
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      pinned_in = pinned_ff;
      rank_in   = rank_ff;
      table_in  = table_ff;
      page_in   = page_ff;
      unique case (cmd.op)
         CMD_MRU, CMD_FILL: begin
            if (sel) begin
               rank_in   = '0;
               pinned_in = 1'b1;
               if (cmd.op == CMD_FILL) begin
                  valid_in = 1'b1;
                  dirty_in = 1'b0;
                  table_in = cmd.tbl;
                  page_in  = cmd.page;
               end
            end else if (rank_ff < rank_ref) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         CMD_UNPIN: begin
            if (sel) begin
               dirty_in  = dirty_ff | cmd.dirty;
               pinned_in = 1'b0;
            end
         end
         CMD_FREE: begin
            if (sel) begin
               valid_in  = 1'b0;
               dirty_in  = 1'b0;
               pinned_in = 1'b0;
               rank_in   = RW'(FRAMES - 1);
            end else if (rank_ff > rank_ref) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dirty_ff  <= 1'b0;
         pinned_ff <= 1'b0;
         rank_ff   <= RW'(INDEX);
         table_ff  <= '0;
         page_ff   <= '0;
      end else begin
         valid_ff  <= valid_in;
         dirty_ff  <= dirty_in;
         pinned_ff <= pinned_in;
         rank_ff   <= rank_in;
         table_ff  <= table_in;
         page_ff   <= page_in;
      end
   end

   assign valid     = valid_ff;
   assign dirty     = dirty_ff;
   assign pinned    = pinned_ff;
   assign rank      = rank_ff;
   assign tag_table = table_ff;
   assign tag_page  = page_ff;
endmodule

// ----- design/lru_buffer_pool_with_pinning_core.sv -----
// LRU buffer pool tag/replacement controller: top level over a row of lbp_cell; needs lbp_pkg.
// Steps: latch on start, match in S_MATCH, decide in S_DECIDE, then the registered strobe;
//   a read miss with an unpinned in-use frame adds a victim search by descending rank (S_SCAN).
// A new request is taken only while idle; busy high until strobe.
// Synchronous active-high reset: all frames invalid, frame 0 most recent, frames in use set to 16.
// The result strobe lasts one cycle; the receiver cannot stall.
module lru_buffer_pool_with_pinning_core #(
   parameter int FRAMES = lbp_pkg::FRAMES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_mode,
   input  logic [15:0]               req_table,
   input  logic [31:0]               req_page,
   input  logic                      req_dirty_flag,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [lbp_pkg::FRAME_W-1:0] rsp_frame,
   output logic                      rsp_writeback,
   output logic [15:0]               rsp_wb_table,
   output logic [31:0]               rsp_wb_page,
   input  logic                      csr_we,
   input  logic [lbp_pkg::CSR_W-1:0] csr_wdata
);
   import lbp_pkg::*;

   localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   state_type state_ff, state_in;

   // latched request
   logic [1:0]  mode_ff;
   logic [15:0] table_ff;
   logic [31:0] page_ff;
   logic        dflag_ff;
   logic [CSR_W-1:0] frames_ff;

   // per-cell views
   logic [FRAMES:0]   first_chain;
   logic [FRAMES-1:0] hit_vec, hit_vec_ff, in_use, sel_vec, vict_vec;
   logic [FRAMES-1:0] c_valid, c_dirty, c_pinned;
   logic [RW-1:0]     c_rank [FRAMES];
   logic [15:0]       c_table [FRAMES];
   logic [31:0]       c_page [FRAMES];

   logic [RW-1:0] rank_ptr_ff, rank_ptr_in, rank_ref;
   cell_cmd_type  cmd;

   // gathered values of the selected frame
   logic [RW-1:0] sel_idx, sel_rank;
   logic [15:0]   sel_table;
   logic [31:0]   sel_page;
   logic          sel_pinned, sel_wb, hit_any, vict_any, free_any;

   logic       rsp_valid_in;
   logic [2:0] rsp_status_in;
   logic       rsp_wb_in;
   logic [15:0] rsp_wbt_in;
   logic [31:0] rsp_wbp_in;
   logic [RW+FRAME_W-1:0] frame_wide;
   logic       rsp_valid_ff, rsp_wb_ff;
   logic [2:0] rsp_status_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [15:0] rsp_wbt_ff;
   logic [31:0] rsp_wbp_ff;

   assign first_chain[0] = 1'b0;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      assign in_use[i]   = (i < int'(frames_ff));
      assign vict_vec[i] = in_use[i] & ~c_pinned[i] & (c_rank[i] == rank_ptr_ff);
      lbp_cell #(.FRAMES(FRAMES), .RW(RW), .INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .sel       (sel_vec[i]),
         .rank_ref  (rank_ref),
         .in_use    (in_use[i]),
         .req_table (table_ff),
         .req_page  (page_ff),
         .first_in  (first_chain[i]),
         .first_out (first_chain[i+1]),
         .hit       (hit_vec[i]),
         .valid     (c_valid[i]),
         .dirty     (c_dirty[i]),
         .pinned    (c_pinned[i]),
         .rank      (c_rank[i]),
         .tag_table (c_table[i]),
         .tag_page  (c_page[i])
      );
   end

   // in scan the victim is the selected frame, otherwise the registered hit
   assign sel_vec = (state_ff == S_SCAN) ? vict_vec : hit_vec_ff;

   // one-hot OR mux over the row
   always_comb begin
      sel_idx    = '0;
      sel_rank   = '0;
      sel_table  = '0;
      sel_page   = '0;
      sel_pinned = 1'b0;
      sel_wb     = 1'b0;
      free_any   = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
         if (sel_vec[i]) begin
            sel_idx    = sel_idx | RW'(i);
            sel_rank   = sel_rank | c_rank[i];
            sel_table  = sel_table | c_table[i];
            sel_page   = sel_page | c_page[i];
            sel_pinned = sel_pinned | c_pinned[i];
            sel_wb     = sel_wb | (c_valid[i] & c_dirty[i]);
         end
         free_any = free_any | (in_use[i] & ~c_pinned[i]);
      end
   end

   assign hit_any  = |hit_vec_ff;
   assign vict_any = |vict_vec;
   assign rank_ref = sel_rank;

   // next state
   always_comb begin
      state_in    = state_ff;
      rank_ptr_in = rank_ptr_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_MATCH;
         S_MATCH:  state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_IDLE;
            if (mode_ff == MODE_READ && !hit_any && free_any) begin
               state_in    = S_SCAN;
               rank_ptr_in = RW'(FRAMES - 1);
            end
         end
         S_SCAN: begin
            if (vict_any) state_in = S_IDLE;
            else rank_ptr_in = rank_ptr_ff - 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: cell command and result
   always_comb begin
      cmd           = '{op: CMD_NONE, tbl: table_ff, page: page_ff,
                        dirty: dflag_ff};
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_wb_in     = 1'b0;
      rsp_wbt_in    = '0;
      rsp_wbp_in    = '0;
      frame_wide    = '0;
      unique case (state_ff)
         S_DECIDE: begin
            unique case (mode_ff)
               MODE_READ: begin
                  if (hit_any) begin
                     rsp_valid_in = 1'b1;
                     frame_wide   = (RW+FRAME_W)'(sel_idx);
                     if (sel_pinned) begin
                        rsp_status_in = ST_BUSY;
                     end else begin
                        rsp_status_in = ST_HIT;
                        cmd.op        = CMD_MRU;
                     end
                  end else if (!free_any) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_BYPASS;
                  end
               end
               MODE_UNPIN: begin
                  rsp_valid_in = 1'b1;
                  if (hit_any) begin
                     cmd.op = CMD_UNPIN;
                  end else if (dflag_ff) begin
                     rsp_wb_in  = 1'b1;
                     rsp_wbt_in = table_ff;
                     rsp_wbp_in = page_ff;
                  end
               end
               MODE_FREE: begin
                  rsp_valid_in = 1'b1;
                  if (hit_any) cmd.op = CMD_FREE;
               end
               MODE_NOP: rsp_valid_in = 1'b1;
               default: ;
            endcase
         end
         S_SCAN: begin
            if (vict_any) begin
               cmd.op        = CMD_FILL;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FILL;
               frame_wide    = (RW+FRAME_W)'(sel_idx);
               if (sel_wb) begin
                  rsp_wb_in  = 1'b1;
                  rsp_wbt_in = sel_table;
                  rsp_wbp_in = sel_page;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         frames_ff    <= FRAMES_IN_USE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) frames_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rank_ptr_ff <= rank_ptr_in;
      if (state_ff == S_IDLE && start) begin
         mode_ff  <= req_mode;
         table_ff <= req_table;
         page_ff  <= req_page;
         dflag_ff <= req_dirty_flag;
      end
      if (state_ff == S_MATCH) hit_vec_ff <= hit_vec;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= frame_wide[FRAME_W-1:0];
      rsp_wb_ff     <= rsp_wb_in;
      rsp_wbt_ff    <= rsp_wbt_in;
      rsp_wbp_ff    <= rsp_wbp_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_frame     = rsp_frame_ff;
   assign rsp_writeback = rsp_wb_ff;
   assign rsp_wb_table  = rsp_wbt_ff;
   assign rsp_wb_page   = rsp_wbp_ff;

`ifndef SYNTHESIS
   // a result only follows a cycle of work on a request
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != S_IDLE)) else $error("result without request");
   // tags among in-use frames give one first match at most
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec)) else $error("multiple first matches");
   // ranks are a permutation, so one victim candidate at most per scan step
   a_victim_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> $onehot0(vict_vec)) else $error("multiple victims");
`endif
endmodule
